>>> rtl/core/matrix_stack_transform_engine_core_assert.svh
// assertion macros shared by the transform engine rtl
`ifndef MATRIX_STACK_TRANSFORM_ENGINE_CORE_ASSERT_SVH
`define MATRIX_STACK_TRANSFORM_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MSTE_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define MSTE_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MSTE_ASSERT(lbl, clk, rstn, prop)
`define MSTE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/core/mste_pkg.sv
`timescale 1ns / 1ps

package mste_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int SLOT_W      = $clog2(2 * STACK_DEPTH);
	localparam int MEM_AW      = SLOT_W + 4;
	localparam int MEM_DEPTH   = 2 * STACK_DEPTH * 16;
	localparam int ACC_W       = 2 * DATA_W + 2;
	localparam int SEQ_W       = 6;

	localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		REQ_SELECT = 4'd0,
		REQ_IDENT  = 4'd1,
		REQ_LOAD   = 4'd2,
		REQ_MULT   = 4'd3,
		REQ_TRANS  = 4'd4,
		REQ_SCALE  = 4'd5,
		REQ_PUSH   = 4'd6,
		REQ_POP    = 4'd7,
		REQ_VERTEX = 4'd8
	} req_code_t;

	typedef enum logic [1:0] {
		SEL_MODELVIEW  = 2'd0,
		SEL_PROJECTION = 2'd1
	} sel_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		JOB_MVP,
		JOB_MULT,
		JOB_TRANS,
		JOB_SCALE,
		JOB_VERT
	} job_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_COPY,
		S_IDENT,
		S_PUSH,
		S_POP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [3:0]               req_type;
		logic [1:0]               matrix_select;
		logic [3:0]               element_index;
		logic                     last_element;
		logic signed [DATA_W-1:0] arg_x;
		logic signed [DATA_W-1:0] arg_y;
		logic signed [DATA_W-1:0] arg_z;
		logic signed [DATA_W-1:0] arg_w;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic signed [DATA_W-1:0] out_w;
		logic                     vertex_valid;
		logic [1:0]               status;
	} result_t;

	typedef struct packed {
		logic                     valid;
		logic                     first;
		logic                     last;
		job_t                     job;
		logic [3:0]               dot;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic signed [DATA_W-1:0] addend;
	} mac_issue_t;

	typedef struct packed {
		logic                     valid;
		job_t                     job;
		logic [3:0]               dot;
		logic signed [DATA_W-1:0] value;
	} mac_wb_t;

	function automatic logic signed [DATA_W-1:0] ident_elem(input logic [3:0] idx);
		return (idx[1:0] == idx[3:2]) ? ONE_FX : '0;
	endfunction

endpackage

>>> rtl/core/mste_mac.sv
`timescale 1ns / 1ps
`include "matrix_stack_transform_engine_core_assert.svh"

module mste_mac
	import mste_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  mac_issue_t iss,
	output mac_wb_t    wb,
	output logic       busy
);

	localparam int SUM_W = ACC_W + 1;

	mac_issue_t                iss_s1;
	mac_issue_t                ctl_s2;
	mac_issue_t                ctl_s3;
	logic signed [2*DATA_W-1:0] p_s2;
	logic signed [ACC_W-1:0]    acc_s3;
	logic signed [SUM_W-1:0]    sum;
	logic signed [DATA_W-1:0]   sat;
	logic                       wb_valid_q;
	job_t                       wb_job_q;
	logic [3:0]                 wb_dot_q;
	logic signed [DATA_W-1:0]   wb_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			wb_valid_q <= 1'b0;
		end else begin
			iss_s1 <= iss;
			ctl_s2 <= iss_s1;
			ctl_s3 <= ctl_s2;
			wb_valid_q <= ctl_s3.valid && ctl_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		p_s2 <= iss_s1.a * iss_s1.b;
		if (ctl_s2.valid) begin
			acc_s3 <= (ctl_s2.first ? ACC_W'(0) : acc_s3) + ACC_W'(p_s2);
		end
		wb_job_q   <= ctl_s3.job;
		wb_dot_q   <= ctl_s3.dot;
		wb_value_q <= sat;
	end

	// floor shift of the exact sum, then addend, then clamp
	always_comb begin
		sum = SUM_W'(acc_s3 >>> FRAC_BITS) + SUM_W'(ctl_s3.addend);
		if (sum[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){sum[SUM_W-1]}}) begin
			sat = sum[DATA_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_comb begin
		wb.valid = wb_valid_q;
		wb.job   = wb_job_q;
		wb.dot   = wb_dot_q;
		wb.value = wb_value_q;
	end

	assign busy = iss_s1.valid || ctl_s2.valid || ctl_s3.valid || wb_valid_q;

	`MSTE_ASSERT(a_wb_follows_last, clk, arst_n, wb.valid |-> $past(iss.valid && iss.last, 4))
	`MSTE_ASSERT(a_last_gives_wb, clk, arst_n, ctl_s3.valid && ctl_s3.last |=> wb.valid)
	`MSTE_ASSERT(a_terms_contiguous, clk, arst_n, iss_s1.valid && !iss_s1.first |-> $past(iss_s1.valid))

endmodule

>>> rtl/core/matrix_stack_transform_engine_core.sv
`timescale 1ns / 1ps
`include "matrix_stack_transform_engine_core_assert.svh"
// 4x4 fixed point (q16.16) transform engine with modelview/projection stacks.
// command channel: cmd is taken when start is high and busy is low. busy stays
// high until the result has been shown.
// result channel: result is valid for one cycle while done is high; the
// receiver must take it then, it cannot stall the block.
// every command gives exactly one result; status reports invalid codes and
// stack under/overflow, vertex results carry vertex_valid.
// all arithmetic runs through one 32x32 multiply-accumulate unit with a
// four-stage pipe; a dot product issues four terms, one per cycle.
// work per command, from accept to done (the next command is taken in the
// cycle after done): select, refused push/pop and a plain multiply element
// go straight to done. vertex: 16 issues and a drain. load element: one
// 64-term product refresh; identity: 16 writes + refresh; translate: 16
// terms + refresh; scale: 48 terms + refresh. multiply commit: 64 terms, a
// 16-element copy + refresh. push: 16 writes; pop: 16 reads + refresh.
// reset: matrices become identity, modelview is selected, stacks are empty.
// stack memory contents are not cleared.

module matrix_stack_transform_engine_core
	import mste_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	state_t                   state_q, state_d;
	logic [SEQ_W-1:0]         seq_q, seq_d;
	job_t                     job_q, job_d;
	status_t                  status_q, status_d;
	logic                     mode_q, mode_d;
	logic                     isvert_q, isvert_d;
	logic [SLOT_W-1:0]        slot_q, slot_d;
	logic [CNT_W-1:0]         mv_cnt_q, pj_cnt_q, cur_cnt;
	logic                     cnt_inc, cnt_dec;
	cmd_t                     cmd_q;

	logic signed [DATA_W-1:0] mv_q  [16];
	logic signed [DATA_W-1:0] pj_q  [16];
	logic signed [DATA_W-1:0] mvp_q [16];
	logic signed [DATA_W-1:0] op_q  [16];
	logic signed [DATA_W-1:0] tmp_q [16];
	logic signed [DATA_W-1:0] vx_q  [4];
	logic signed [DATA_W-1:0] mem_q [MEM_DEPTH];
	logic signed [DATA_W-1:0] mem_rd_q;
	logic                     pop_v_q;
	logic [3:0]               pop_idx_q;

	logic [3:0]               cur_ra, mv_ra, pj_ra, op_ra, mvp_ra;
	logic signed [DATA_W-1:0] mv_rd, pj_rd, cur_rd, op_rd, mvp_rd;
	logic                     cur_we, op_we, mem_we, mem_re;
	logic [3:0]               cur_wa;
	logic signed [DATA_W-1:0] cur_wd;
	logic [MEM_AW-1:0]        mem_a;
	logic [3:0]               dot, last_dot;
	logic [1:0]               k;
	logic [SLOT_W-1:0]        slot_base;

	mac_issue_t               iss;
	mac_wb_t                  wb;
	logic                     pipe_busy;

	mste_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.iss    (iss),
		.wb     (wb),
		.busy   (pipe_busy)
	);

	function automatic logic signed [DATA_W-1:0] arg_of(input cmd_t c, input logic [1:0] i);
		logic signed [DATA_W-1:0] v;
		case (i)
			2'd0:    v = c.arg_x;
			2'd1:    v = c.arg_y;
			2'd2:    v = c.arg_z;
			default: v = c.arg_w;
		endcase
		return v;
	endfunction

	assign dot       = seq_q[5:2];
	assign k         = seq_q[1:0];
	assign cur_cnt   = mode_q ? pj_cnt_q : mv_cnt_q;
	assign slot_base = mode_q ? SLOT_W'(STACK_DEPTH) : '0;
	assign mem_a     = {slot_q, seq_q[3:0]};

	// read addresses
	always_comb begin
		cur_ra = seq_q[3:0];
		if (state_q == S_RUN) begin
			cur_ra = (job_q == JOB_SCALE) ? dot : {k, dot[1:0]};
		end
		if (state_q == S_RUN && job_q == JOB_MVP) begin
			pj_ra = {k, dot[1:0]};
			mv_ra = {dot[3:2], k};
		end else begin
			pj_ra = cur_ra;
			mv_ra = cur_ra;
		end
		op_ra  = {dot[3:2], k};
		mvp_ra = {k, dot[1:0]};
	end

	assign mv_rd  = mv_q[mv_ra];
	assign pj_rd  = pj_q[pj_ra];
	assign cur_rd = mode_q ? pj_rd : mv_rd;
	assign op_rd  = op_q[op_ra];
	assign mvp_rd = mvp_q[mvp_ra];

	always_comb begin
		unique case (job_q)
			JOB_MVP, JOB_MULT: last_dot = 4'd15;
			JOB_SCALE:         last_dot = 4'd11;
			default:           last_dot = 4'd3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			seq_q    <= '0;
			job_q    <= JOB_MVP;
			status_q <= ST_OK;
			mode_q   <= 1'b0;
			isvert_q <= 1'b0;
			slot_q   <= '0;
			mv_cnt_q <= '0;
			pj_cnt_q <= '0;
			pop_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			seq_q    <= seq_d;
			job_q    <= job_d;
			status_q <= status_d;
			mode_q   <= mode_d;
			isvert_q <= isvert_d;
			slot_q   <= slot_d;
			pop_v_q  <= (state_q == S_POP) && !seq_q[4];
			if (cnt_inc) begin
				if (mode_q) pj_cnt_q <= pj_cnt_q + CNT_W'(1);
				else        mv_cnt_q <= mv_cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				if (mode_q) pj_cnt_q <= pj_cnt_q - CNT_W'(1);
				else        mv_cnt_q <= mv_cnt_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		seq_d    = seq_q;
		job_d    = job_q;
		status_d = status_q;
		mode_d   = mode_q;
		isvert_d = isvert_q;
		slot_d   = slot_q;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		op_we    = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		iss      = '0;
		cur_we   = 1'b0;
		cur_wa   = wb.dot;
		cur_wd   = wb.value;
		if (wb.valid && (wb.job == JOB_TRANS || wb.job == JOB_SCALE)) begin
			cur_we = 1'b1;
			cur_wa = (wb.job == JOB_TRANS) ? {2'b11, wb.dot[1:0]} : wb.dot;
		end
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					status_d = ST_OK;
					isvert_d = 1'b0;
					seq_d    = '0;
					unique case (cmd.req_type)
						REQ_SELECT: begin
							if (cmd.matrix_select == SEL_MODELVIEW ||
							    cmd.matrix_select == SEL_PROJECTION) begin
								mode_d = (cmd.matrix_select == SEL_PROJECTION);
							end else begin
								status_d = ST_INVALID;
							end
							state_d = S_DONE;
						end
						REQ_IDENT: state_d = S_IDENT;
						REQ_LOAD: begin
							cur_we  = 1'b1;
							cur_wa  = cmd.element_index;
							cur_wd  = cmd.arg_x;
							job_d   = JOB_MVP;
							state_d = S_RUN;
						end
						REQ_MULT: begin
							op_we = 1'b1;
							if (cmd.last_element) begin
								job_d   = JOB_MULT;
								state_d = S_RUN;
							end else begin
								state_d = S_DONE;
							end
						end
						REQ_TRANS: begin
							job_d   = JOB_TRANS;
							state_d = S_RUN;
						end
						REQ_SCALE: begin
							job_d   = JOB_SCALE;
							state_d = S_RUN;
						end
						REQ_PUSH: begin
							if (cur_cnt >= CNT_W'(STACK_DEPTH)) begin
								status_d = ST_OVERFLOW;
								state_d  = S_DONE;
							end else begin
								slot_d  = slot_base + SLOT_W'(cur_cnt);
								state_d = S_PUSH;
							end
						end
						REQ_POP: begin
							if (cur_cnt == '0) begin
								status_d = ST_UNDERFLOW;
								state_d  = S_DONE;
							end else begin
								slot_d  = slot_base + SLOT_W'(cur_cnt - CNT_W'(1));
								state_d = S_POP;
							end
						end
						REQ_VERTEX: begin
							isvert_d = 1'b1;
							job_d    = JOB_VERT;
							state_d  = S_RUN;
						end
						default: begin
							status_d = ST_INVALID;
							state_d  = S_DONE;
						end
					endcase
				end
			end
			S_RUN: begin
				iss.valid = 1'b1;
				iss.first = (k == 2'd0);
				iss.last  = (k == 2'd3);
				iss.job   = job_q;
				iss.dot   = dot;
				case (job_q)
					JOB_MVP: begin
						iss.a = pj_rd;
						iss.b = mv_rd;
					end
					JOB_MULT: begin
						iss.a = cur_rd;
						iss.b = op_rd;
					end
					JOB_TRANS: begin
						// fourth term carries the old column 3 element as addend
						if (k == 2'd3) begin
							iss.addend = cur_rd;
						end else begin
							iss.a = arg_of(cmd_q, k);
							iss.b = cur_rd;
						end
					end
					JOB_SCALE: begin
						if (k == 2'd0) begin
							iss.a = arg_of(cmd_q, dot[3:2]);
							iss.b = cur_rd;
						end
					end
					default: begin
						iss.a = mvp_rd;
						iss.b = arg_of(cmd_q, k);
					end
				endcase
				seq_d = seq_q + SEQ_W'(1);
				if (dot == last_dot && k == 2'd3) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!pipe_busy) begin
					seq_d = '0;
					case (job_q)
						JOB_MULT: state_d = S_COPY;
						JOB_TRANS, JOB_SCALE: begin
							job_d   = JOB_MVP;
							state_d = S_RUN;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_COPY, S_IDENT: begin
				cur_we = 1'b1;
				cur_wa = seq_q[3:0];
				cur_wd = (state_q == S_COPY) ? tmp_q[seq_q[3:0]] : ident_elem(seq_q[3:0]);
				seq_d  = seq_q + SEQ_W'(1);
				if (seq_q[3:0] == 4'd15) begin
					seq_d   = '0;
					job_d   = JOB_MVP;
					state_d = S_RUN;
				end
			end
			S_PUSH: begin
				mem_we = 1'b1;
				seq_d  = seq_q + SEQ_W'(1);
				if (seq_q[3:0] == 4'd15) begin
					cnt_inc = 1'b1;
					state_d = S_DONE;
				end
			end
			S_POP: begin
				// read one element ahead, write it back in the next cycle
				mem_re = !seq_q[4];
				if (pop_v_q) begin
					cur_we = 1'b1;
					cur_wa = pop_idx_q;
					cur_wd = mem_rd_q;
				end
				seq_d = seq_q + SEQ_W'(1);
				if (seq_q[4]) begin
					cnt_dec = 1'b1;
					seq_d   = '0;
					job_d   = JOB_MVP;
					state_d = S_RUN;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (op_we) begin
			op_q[cmd.element_index] <= cmd.arg_x;
		end
		if (wb.valid) begin
			case (wb.job)
				JOB_MULT: tmp_q[wb.dot]     <= wb.value;
				JOB_VERT: vx_q[wb.dot[1:0]] <= wb.value;
				default: ;
			endcase
		end
		pop_idx_q <= seq_q[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mv_q[i]  <= ident_elem(4'(i));
				pj_q[i]  <= ident_elem(4'(i));
				mvp_q[i] <= ident_elem(4'(i));
			end
		end else begin
			if (cur_we && !mode_q) mv_q[cur_wa] <= cur_wd;
			if (cur_we && mode_q)  pj_q[cur_wa] <= cur_wd;
			if (wb.valid && wb.job == JOB_MVP) mvp_q[wb.dot] <= wb.value;
		end
	end

	// stack store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_a] <= cur_rd;
		end
		if (mem_re) begin
			mem_rd_q <= mem_q[mem_a];
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		result.out_x        = isvert_q ? vx_q[0] : '0;
		result.out_y        = isvert_q ? vx_q[1] : '0;
		result.out_z        = isvert_q ? vx_q[2] : '0;
		result.out_w        = isvert_q ? vx_q[3] : '0;
		result.vertex_valid = isvert_q;
		result.status       = status_q;
	end

	`MSTE_ASSERT(a_done_then_idle, clk, arst_n, done |=> !busy)
	`MSTE_ASSERT(a_wb_only_in_run, clk, arst_n, wb.valid |-> (state_q == S_RUN || state_q == S_DRAIN))
	`MSTE_ASSERT(a_cnt_bound, clk, arst_n, mv_cnt_q <= CNT_W'(STACK_DEPTH) && pj_cnt_q <= CNT_W'(STACK_DEPTH))
	`MSTE_ASSERT_ALWAYS(a_vertex_ok, clk, result.vertex_valid |-> result.status == ST_OK)

endmodule
